// File: src/crc32rc_pkg.sv
// crc32rc_pkg: shared types, constants and the crc byte update for the record checker
// no dependencies; imported by crc32rc_engine and crc32_record_checker_core
package crc32rc_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;

    // request codes
    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_VERIFY   = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ERASED   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    // one input transaction: a record byte
    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] stored_crc;
    } req_t;

    // one output transaction: the finished record check
    typedef struct packed {
        logic [31:0] crc_value;
        logic [1:0]  status;
    } rsp_t;

    // reflected crc-32, one byte, eight shift-xor steps
    function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                    input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/crc32rc_engine.sv
// crc32rc_engine: running crc and erased flag of the current record, plus result logic
// depends on crc32rc_pkg
module crc32rc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  crc32rc_pkg::req_t   item,
    output crc32rc_pkg::rsp_t   result
);
    import crc32rc_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        erased_reg;
    logic        erased_next;
    logic [31:0] crc_upd;
    logic        erased_upd;
    logic [31:0] final_crc;

    // byte update and erased tracking
    always_comb
    begin
        crc_upd    = crc_byte_update(crc_reg, item.data_byte);
        erased_upd = erased_reg && (item.data_byte == ERASED_BYTE);
        final_crc  = crc_upd ^ CRC_ONES;
    end

    // result of the record, meaningful when the byte is the last one
    always_comb
    begin
        result.crc_value = final_crc;
        result.status    = STATUS_OK;
        if (item.req_type == REQ_VERIFY)
        begin
            if (erased_upd && (item.stored_crc == CRC_ONES))
            begin
                result.status = STATUS_ERASED;
            end
            else if (final_crc != item.stored_crc)
            begin
                result.status = STATUS_MISMATCH;
            end
        end
    end

    // state update, re-arm at the end of a record
    always_comb
    begin
        crc_next    = crc_reg;
        erased_next = erased_reg;
        if (step)
        begin
            if (item.last_byte)
            begin
                crc_next    = CRC_ONES;
                erased_next = 1'b1;
            end
            else
            begin
                crc_next    = crc_upd;
                erased_next = erased_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_ONES;
            erased_reg <= 1'b1;
        end
        else
        begin
            crc_reg    <= crc_next;
            erased_reg <= erased_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a finished record leaves the state re-armed
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> crc_reg == CRC_ONES && erased_reg)
        else $error("state not re-armed after last byte");

    // the erased flag never comes back inside a record
    a_erased_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !erased_reg && !(step && item.last_byte) |=> !erased_reg)
        else $error("erased flag set again within a record");

    // generate requests always report ok
    a_gen_ok: assert property (@(posedge clk) disable iff (!rst_n)
        item.req_type == REQ_GENERATE |-> result.status == STATUS_OK)
        else $error("generate request with non-ok status");
`endif

endmodule

// File: src/crc32_record_checker_core.sv
// crc32_record_checker_core: top level of the crc-32 record checker
// depends on crc32rc_pkg and crc32rc_engine
//
// Takes one record byte per transaction and returns one result per record, on
// its last byte: the reflected crc-32 (ieee 802.3) and, for verify requests, a
// status of ok, erased or mismatch. A new byte is accepted every cycle while
// req_stall is low; the result of a record is computed from the input register
// into the result register, from which it is offered on rsp.
// The cycle is set by the eight-step unrolled crc byte update that sits between
// the input register and the result register. Stall on the byte side rises only
// while a last byte waits for the result register to free up.
module crc32_record_checker_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  crc32rc_pkg::req_t   req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output crc32rc_pkg::rsp_t   rsp
);
    import crc32rc_pkg::*;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    req_t  s1_item_reg;
    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    rsp_t  rsp_reg;
    rsp_t  result;
    logic  rsp_free;
    logic  s1_fire;
    logic  req_fire;

    // stage handshake: non-last bytes always move on, last bytes need the result slot
    always_comb
    begin
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        s1_fire   = s1_valid_reg && (!s1_item_reg.last_byte || rsp_free);
        req_stall = s1_valid_reg && !s1_fire;
        req_fire  = req_valid && !req_stall;
    end

    // input register occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // result register occupancy
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_fire && s1_item_reg.last_byte)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    crc32rc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .item   (s1_item_reg),
        .result (result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg <= req;
        end
        if (s1_fire && s1_item_reg.last_byte)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // a result only appears after a last byte left the input register
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(s1_fire && s1_item_reg.last_byte))
        else $error("result without a last byte");

    // stall only while the input register holds a blocked last byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && s1_item_reg.last_byte && rsp_valid_reg && rsp_stall)
        else $error("input stalled without cause");

    // a held result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |-> !(s1_fire && s1_item_reg.last_byte))
        else $error("result register overwritten while stalled");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.status == STATUS_OK || rsp_reg.status == STATUS_ERASED
                          || rsp_reg.status == STATUS_MISMATCH)
        else $error("undefined status code");
`endif

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for crc32_record_checker_core, record crc and verify status
// depends on crc32rc_pkg and the crc32_record_checker_core rtl; reads no files
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc32rc_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE_WAIT  = 10;

    // tracks the running crc of the open record and queues the finished checks
    class record_crc_board;
        logic [31:0] running;
        bit          erased_so_far;
        rsp_t        awaited[$];
        int          error_count;

        function new();
            running       = CRC_ONES;
            erased_so_far = 1'b1;
            error_count   = 0;
        endfunction

        // reflected crc-32, one byte, lsb first
        static function logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] data);
            logic [31:0] acc;
            acc = crc;
            for (int b = 0; b < 8; b++)
            begin
                acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0] ^ data[b]}});
            end
            return acc;
        endfunction

        // accepted byte transaction: advance the record, queue a check on the last byte
        function void absorb_byte(input req_t t);
            rsp_t want;
            running = fold_byte(running, t.data_byte);
            if (t.data_byte != ERASED_BYTE)
            begin
                erased_so_far = 1'b0;
            end
            if (t.last_byte)
            begin
                want.crc_value = running ^ CRC_ONES;
                want.status    = STATUS_OK;
                if (t.req_type == REQ_VERIFY)
                begin
                    if (erased_so_far && t.stored_crc == CRC_ONES)
                    begin
                        want.status = STATUS_ERASED;
                    end
                    else if (want.crc_value != t.stored_crc)
                    begin
                        want.status = STATUS_MISMATCH;
                    end
                end
                awaited.push_back(want);
                running       = CRC_ONES;
                erased_so_far = 1'b1;
            end
        endfunction

        // accepted result transaction against the oldest queued check
        function void match_result(input rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got crc %h status %0d",
                         $time, got.crc_value, got.status);
                error_count++;
                return;
            end
            want = awaited.pop_front();
            if (got.crc_value !== want.crc_value)
            begin
                $display("%0t: crc_value mismatch, expected %h, got %h",
                         $time, want.crc_value, got.crc_value);
                error_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    record_crc_board board = new();
    int  items_sent = 0;
    int  cycle_count = 0;
    int  rsp_hold_cycles = 0;
    bit  sender_quiet = 1'b0;

    crc32_record_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            board.match_result(rsp);
        end
    end

    // result side stall pattern, with quiet stretches and the long hold-off
    initial
    begin
        int stall_len;
        bit quiet;
        quiet = 1'b0;
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall_len       = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    quiet = !quiet;
                end
                stall_len = quiet ? 0 : $urandom_range(0, 19);
            end
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    // offer one byte transaction after a random gap and wait for acceptance
    task automatic send_byte(input req_t item);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        board.absorb_byte(item);
        items_sent++;
    endtask

    // crc of a whole record payload
    function automatic logic [31:0] record_crc(input logic [7:0] payload[$]);
        logic [31:0] acc;
        acc = CRC_ONES;
        foreach (payload[i])
        begin
            acc = record_crc_board::fold_byte(acc, payload[i]);
        end
        return acc ^ CRC_ONES;
    endfunction

    // send a record; earlier bytes carry random request type and stored crc
    task automatic send_record(input logic [7:0] payload[$], input logic mode,
                               input logic [31:0] stored);
        req_t item;
        int   n;
        n = payload.size();
        for (int i = 0; i < n; i++)
        begin
            item.data_byte = payload[i];
            item.last_byte = (i == n - 1);
            item.req_type  = (i == n - 1) ? mode : logic'($urandom_range(0, 1));
            item.stored_crc = (i == n - 1) ? stored : $urandom();
            send_byte(item);
        end
    endtask

    // random record of the given length, some fully erased
    task automatic send_random_record(input int len);
        logic [7:0]  payload[$];
        logic [31:0] good;
        logic [31:0] stored;
        logic        mode;
        bit          erased_fill;
        int          pick;
        erased_fill = ($urandom_range(0, 99) < 15);
        for (int i = 0; i < len; i++)
        begin
            payload.push_back(erased_fill ? ERASED_BYTE : 8'($urandom_range(0, 255)));
        end
        good = record_crc(payload);
        mode = ($urandom_range(0, 99) < 60) ? REQ_VERIFY : REQ_GENERATE;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            stored = good;
        end
        else if (pick < 55)
        begin
            stored = CRC_ONES;
        end
        else if (pick < 75)
        begin
            stored = good ^ (32'h1 << $urandom_range(0, 31));
        end
        else
        begin
            stored = $urandom();
        end
        send_record(payload, mode, stored);
    endtask

    // stimulus and end of run
    initial
    begin
        logic [7:0] payload[$];
        int         len;
        int         pick;
        bit         pressure_done;
        pressure_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // generate mode, zero byte, stored crc ignored
        payload = '{8'h00};
        send_record(payload, REQ_GENERATE, 32'h0000_0000);
        payload = '{8'hFF};
        send_record(payload, REQ_GENERATE, CRC_ONES);
        // erased record in verify mode
        payload = '{8'hFF, 8'hFF};
        send_record(payload, REQ_VERIFY, CRC_ONES);
        // all erased bytes but stored crc not erased: plain comparison
        send_record(payload, REQ_VERIFY, 32'h0000_0000);
        // standard check string with mixed request types before the last byte
        payload = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_record(payload, REQ_VERIFY, 32'hCBF4_3926);
        // one non-erased byte spoils the erased case
        payload = '{8'hFF, 8'h00};
        send_record(payload, REQ_VERIFY, CRC_ONES);
        // single byte, correct and flipped stored crc
        payload = '{8'h5A};
        send_record(payload, REQ_VERIFY, record_crc(payload));
        payload = '{8'hAA};
        send_record(payload, REQ_VERIFY, record_crc(payload) ^ 32'h8000_0000);

        // random records
        while (items_sent < ITEM_TARGET)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            if (!pressure_done && items_sent >= ITEM_TARGET / 2)
            begin
                // receiver holds off while single byte records stream in back to back
                pressure_done   = 1'b1;
                sender_quiet    = 1'b1;
                rsp_hold_cycles = HOLD_CYCLES;
                repeat (40) send_random_record(1);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    len = $urandom_range(1, 4);
                end
                else if (pick < 85)
                begin
                    len = $urandom_range(5, 16);
                end
                else
                begin
                    len = $urandom_range(17, 64);
                end
                send_random_record(len);
            end
        end
        req_valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (board.error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
